// ===== rtl/core/grpc_pkg.sv =====
`default_nettype none

package grpc_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 32;
  localparam int RADIUS_W       = 31;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      point_last;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic                      centroid_last;
  } centroid_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LSCAN,
    ST_LCAP,
    ST_INNER,
    ST_DRAIN,
    ST_DWAIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic store;
    logic rsq_load;
    logic i_clear;
    logic i_inc;
    logic lead_rd;
    logic lead_cap;
    logic j_load;
    logic j_issue;
    logic div_start;
    logic out_load;
    logic list_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic i_at_end;
    logic i_marked;
    logic j_at_end;
    logic pipe_busy;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/grpc_div.sv =====
`default_nettype none

module grpc_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic        [DEN_W-1:0] den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quo
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  num_mag;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              take;
  logic              last_step;

  assign num_mag   = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign rem_sh    = {rem_r, quo_r[NUM_W-1]};
  assign rem_sub   = rem_sh - {1'b0, den_r};
  assign take      = (rem_sh >= {1'b0, den_r});
  assign last_step = (step_r == STEP_W'(NUM_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], take};
      rem_r <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = $signed(neg_r ? (~quo_r + 1'b1) : quo_r);

endmodule

`default_nettype wire

// ===== rtl/core/grpc_dp.sv =====
`default_nettype none

module grpc_dp #(
  parameter int MAX_POINTS = grpc_pkg::MAX_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [grpc_pkg::RADIUS_W-1:0]   cfg_wr_data,
  input  wire grpc_pkg::point_t                in_data,
  input  wire grpc_pkg::dp_cmd_t               cmd,
  output grpc_pkg::dp_stat_t                   stat,
  output grpc_pkg::centroid_t                  out_data
);

  localparam int COORD_W  = grpc_pkg::COORD_W;
  localparam int RADIUS_W = grpc_pkg::RADIUS_W;
  localparam int IDX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W    = COORD_W + CNT_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * RADIUS_W;

  logic [COORD_W-1:0] mem_x [MAX_POINTS];
  logic [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [COORD_W-1:0] rd_x_r, rd_y_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  logic [RADIUS_W-1:0] radius_r;
  logic [SQ_W-1:0]     rsq_r;
  logic [SQ_W-1:0]     rsq_prod;

  logic [CNT_W-1:0]   n_r, i_r, j_r, total_r, cnt_r;
  logic [MAX_POINTS-1:0] mark_r;
  logic [COORD_W-1:0] lead_x_r, lead_y_r;
  logic [SUM_W-1:0]   sum_x_r, sum_y_r;

  logic               v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]   j1_r, j2_r, j3_r;
  logic [COORD_W-1:0] px2_r, py2_r, px3_r, py3_r;
  logic [RADIUS_W-1:0] dx2_r, dy2_r;
  logic [SQ_W-1:0]    sqx3_r, sqy3_r;
  logic [SQ_W-1:0]    sqx_prod, sqy_prod;

  logic [DIFF_W-1:0]  dx_full, dy_full, dx_mag, dy_mag;
  logic               near;
  logic               v0;
  logic [SQ_W:0]      sq_sum;
  logic               hit;

  logic               div_done_x, div_done_y;
  logic signed [SUM_W-1:0] quo_x, quo_y;

  assign wr_en   = cmd.store && (n_r < CNT_W'(MAX_POINTS));
  assign rd_addr = cmd.lead_rd ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[n_r[IDX_W-1:0]] <= in_data.point_x;
      mem_y[n_r[IDX_W-1:0]] <= in_data.point_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign rsq_prod = radius_r * radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsq_load) begin
      rsq_r <= rsq_prod;
    end
  end

  // Candidate pipeline: fetch, offset check, squares, radius compare.
  assign v0 = cmd.j_issue && !mark_r[j_r[IDX_W-1:0]];

  assign dx_full = {rd_x_r[COORD_W-1], rd_x_r} - {lead_x_r[COORD_W-1], lead_x_r};
  assign dy_full = {rd_y_r[COORD_W-1], rd_y_r} - {lead_y_r[COORD_W-1], lead_y_r};
  assign dx_mag  = dx_full[DIFF_W-1] ? (~dx_full + 1'b1) : dx_full;
  assign dy_mag  = dy_full[DIFF_W-1] ? (~dy_full + 1'b1) : dy_full;
  assign near    = (dx_mag <= DIFF_W'(radius_r)) && (dy_mag <= DIFF_W'(radius_r));

  assign sqx_prod = dx2_r * dx2_r;
  assign sqy_prod = dy2_r * dy2_r;

  assign sq_sum = {1'b0, sqx3_r} + {1'b0, sqy3_r};
  assign hit    = v3_r && (sq_sum <= {1'b0, rsq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v0;
      v2_r <= v1_r && near;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r   <= j_r[IDX_W-1:0];
    j2_r   <= j1_r;
    j3_r   <= j2_r;
    px2_r  <= rd_x_r;
    py2_r  <= rd_y_r;
    px3_r  <= px2_r;
    py3_r  <= py2_r;
    dx2_r  <= dx_mag[RADIUS_W-1:0];
    dy2_r  <= dy_mag[RADIUS_W-1:0];
    sqx3_r <= sqx_prod;
    sqy3_r <= sqy_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      total_r <= '0;
      mark_r  <= '0;
    end else begin
      if (wr_en) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.i_clear) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.j_load) begin
        j_r <= i_r + 1'b1;
      end else if (cmd.j_issue) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.list_clear) begin
        n_r     <= '0;
        total_r <= '0;
        mark_r  <= '0;
      end else if (cmd.lead_cap) begin
        total_r                  <= total_r + 1'b1;
        mark_r[i_r[IDX_W-1:0]]   <= 1'b1;
      end else if (hit) begin
        total_r      <= total_r + 1'b1;
        mark_r[j3_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lead_cap) begin
      lead_x_r <= rd_x_r;
      lead_y_r <= rd_y_r;
      sum_x_r  <= {{(SUM_W-COORD_W){rd_x_r[COORD_W-1]}}, rd_x_r};
      sum_y_r  <= {{(SUM_W-COORD_W){rd_y_r[COORD_W-1]}}, rd_y_r};
      cnt_r    <= CNT_W'(1);
    end else if (hit) begin
      sum_x_r <= sum_x_r + {{(SUM_W-COORD_W){px3_r[COORD_W-1]}}, px3_r};
      sum_y_r <= sum_y_r + {{(SUM_W-COORD_W){py3_r[COORD_W-1]}}, py3_r};
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  grpc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ($signed(sum_x_r)),
    .den   (cnt_r),
    .done  (div_done_x),
    .quo   (quo_x)
  );

  grpc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ($signed(sum_y_r)),
    .den   (cnt_r),
    .done  (div_done_y),
    .quo   (quo_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.centroid_x    <= quo_x[COORD_W-1:0];
      out_data.centroid_y    <= quo_y[COORD_W-1:0];
      out_data.centroid_last <= (total_r == n_r);
    end
  end

  assign stat.i_at_end  = (i_r == n_r);
  assign stat.i_marked  = mark_r[i_r[IDX_W-1:0]];
  assign stat.j_at_end  = (j_r == n_r);
  assign stat.pipe_busy = v1_r || v2_r || v3_r;
  assign stat.div_done  = div_done_x && div_done_y;

endmodule

`default_nettype wire

// ===== rtl/core/grpc_ctrl.sv =====
`default_nettype none

module grpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  input  wire logic               out_ready,
  input  wire grpc_pkg::dp_stat_t stat,
  output logic                    in_ready,
  output logic                    out_valid,
  output grpc_pkg::dp_cmd_t       cmd
);

  grpc_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      grpc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            state_nxt = grpc_pkg::ST_INIT;
          end
        end
      end
      grpc_pkg::ST_INIT: begin
        cmd.rsq_load = 1'b1;
        cmd.i_clear  = 1'b1;
        state_nxt    = grpc_pkg::ST_LSCAN;
      end
      grpc_pkg::ST_LSCAN: begin
        if (stat.i_at_end) begin
          cmd.list_clear = 1'b1;
          state_nxt      = grpc_pkg::ST_IDLE;
        end else if (stat.i_marked) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.lead_rd = 1'b1;
          state_nxt   = grpc_pkg::ST_LCAP;
        end
      end
      grpc_pkg::ST_LCAP: begin
        cmd.lead_cap = 1'b1;
        cmd.j_load   = 1'b1;
        state_nxt    = grpc_pkg::ST_INNER;
      end
      grpc_pkg::ST_INNER: begin
        if (stat.j_at_end) begin
          state_nxt = grpc_pkg::ST_DRAIN;
        end else begin
          cmd.j_issue = 1'b1;
        end
      end
      grpc_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = grpc_pkg::ST_DWAIT;
        end
      end
      grpc_pkg::ST_DWAIT: begin
        if (stat.div_done) begin
          cmd.out_load = 1'b1;
          state_nxt    = grpc_pkg::ST_OUT;
        end
      end
      grpc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.i_inc = 1'b1;
          state_nxt = grpc_pkg::ST_LSCAN;
        end
      end
      default: begin
        state_nxt = grpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/greedy_radius_point_clustering.sv =====
`default_nettype none

// Channel  | Ports                              | Moves
// ---------+------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data        | one point per transfer
// result   | out_valid, out_ready, out_data     | one cluster centroid per transfer
// config   | cfg_wr_en, cfg_wr_data             | join radius, written at once
//
// Loading takes one point per cycle; the point marked last starts clustering.
// Clustering scans indexes one per cycle; each leader is fetched in ST_LSCAN and ST_LCAP,
// then later indexes issue one per cycle (one read port of the point memory), the distance
// pipeline drains, the dividers run, and the centroid waits in ST_OUT until it is taken.
// Reset is synchronous; no points are accepted until all centroids of a list are taken.

module greedy_radius_point_clustering #(
  parameter int MAX_POINTS = grpc_pkg::MAX_POINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire grpc_pkg::point_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output grpc_pkg::centroid_t                 out_data,
  input  wire logic                           cfg_wr_en,
  input  wire logic [grpc_pkg::RADIUS_W-1:0]  cfg_wr_data
);

  grpc_pkg::dp_cmd_t  cmd;
  grpc_pkg::dp_stat_t stat;

  grpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.point_last),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  grpc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
